// ===== sv/afr_pkg.sv =====
// shared types and constants for the addressed frame receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 4;
    localparam int STATUS_W = 2;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ADDR = 2'd1,
        ST_XOR_FAIL = 2'd2,
        ST_SUM_FAIL = 2'd3
    } t_status;

    // next byte expected within a frame
    typedef enum logic [2:0] {
        POS_IDLE = 3'd0,
        POS_A    = 3'd1,
        POS_B    = 3'd2,
        POS_XOR  = 3'd3,
        POS_SUM  = 3'd4
    } t_pos;

endpackage

`default_nettype wire

// ===== sv/afr_if.sv =====
// valid/ready channel interfaces: received bytes in, frame results out
// depends on afr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface afr_byte_if;
    logic                       valid;
    logic                       ready;
    logic [afr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afr_result_if;
    logic                         valid;
    logic                         ready;
    logic [afr_pkg::STATUS_W-1:0] status;
    logic [afr_pkg::BYTE_W-1:0]   duty_a;
    logic [afr_pkg::BYTE_W-1:0]   duty_b;

    modport source (output valid, output status, output duty_a, output duty_b, input ready);
    modport sink   (input valid, input status, input duty_a, input duty_b, output ready);
endinterface

`default_nettype wire

// ===== sv/addressed_frame_receiver.sv =====
// addressed frame receiver top level: byte input stage, frame parser, result register
// depends on afr_pkg and the channel interfaces in afr_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Collects five-byte frames (address, duty a, duty b, xor check, sum check) from a byte
// stream and updates the two held duty values when both checks pass. A lead byte that is
// not the configured 4-bit address is dropped and reported with status 1; the fifth byte
// of a frame reports status 0 (accepted), 2 (xor check failed) or 3 (sum check failed);
// other bytes give no result. Every result carries the held duty values after it. A byte
// is accepted every cycle while the result side keeps up: it is held in the input
// register, then the parser updates the frame state and loads the result register. A
// result waiting in the output register holds the parser for any byte, and the input
// drops ready once the input register is also occupied. Write the address only while no
// frame is in progress.
module addressed_frame_receiver (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [afr_pkg::ADDR_W-1:0] i_cfg_wdata,
    afr_byte_if.sink                        i_rx,
    afr_result_if.source                    o_res
);

    logic [afr_pkg::ADDR_W-1:0] r_addr;

    logic                       r_stg_valid;
    logic [afr_pkg::BYTE_W-1:0] r_stg_byte;

    afr_pkg::t_pos              r_pos, n_pos;
    logic [afr_pkg::BYTE_W-1:0] r_cand_a, n_cand_a;
    logic [afr_pkg::BYTE_W-1:0] r_cand_b, n_cand_b;
    logic [afr_pkg::BYTE_W-1:0] r_xor, n_xor;
    logic [afr_pkg::BYTE_W-1:0] r_duty_a, n_duty_a;
    logic [afr_pkg::BYTE_W-1:0] r_duty_b, n_duty_b;

    logic                       r_out_valid;
    afr_pkg::t_status           r_out_status, n_out_status;

    logic                       w_emit;
    logic                       w_adv;
    logic [afr_pkg::BYTE_W-1:0] w_addr8;
    logic [afr_pkg::BYTE_W-1:0] w_xor_calc;
    logic [afr_pkg::BYTE_W-1:0] w_sum_calc;

    assign w_addr8    = {{(afr_pkg::BYTE_W - afr_pkg::ADDR_W){1'b0}}, r_addr};
    assign w_xor_calc = w_addr8 ^ r_cand_a ^ r_cand_b;
    assign w_sum_calc = w_addr8 + r_cand_a + r_cand_b;

    // parser moves when its byte is present and the result slot is free or being taken
    assign w_adv      = r_stg_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_stg_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cfg_we) begin
            r_addr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_stg_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_stg_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= afr_pkg::POS_IDLE;
            r_cand_a <= '0;
            r_cand_b <= '0;
            r_xor    <= '0;
            r_duty_a <= '0;
            r_duty_b <= '0;
        end else if (w_adv) begin
            r_pos    <= n_pos;
            r_cand_a <= n_cand_a;
            r_cand_b <= n_cand_b;
            r_xor    <= n_xor;
            r_duty_a <= n_duty_a;
            r_duty_b <= n_duty_b;
        end
    end

    always_comb begin
        n_pos        = afr_pkg::POS_IDLE;
        n_cand_a     = r_cand_a;
        n_cand_b     = r_cand_b;
        n_xor        = r_xor;
        n_duty_a     = r_duty_a;
        n_duty_b     = r_duty_b;
        w_emit       = 1'b0;
        n_out_status = afr_pkg::ST_OK;
        case (r_pos)
            afr_pkg::POS_A: begin
                n_cand_a = r_stg_byte;
                n_pos    = afr_pkg::POS_B;
            end
            afr_pkg::POS_B: begin
                n_cand_b = r_stg_byte;
                n_pos    = afr_pkg::POS_XOR;
            end
            afr_pkg::POS_XOR: begin
                n_xor = r_stg_byte;
                n_pos = afr_pkg::POS_SUM;
            end
            afr_pkg::POS_SUM: begin
                w_emit = 1'b1;
                if (w_xor_calc != r_xor) begin
                    n_out_status = afr_pkg::ST_XOR_FAIL;
                end else if (w_sum_calc != r_stg_byte) begin
                    n_out_status = afr_pkg::ST_SUM_FAIL;
                end else begin
                    n_duty_a = r_cand_a;
                    n_duty_b = r_cand_b;
                end
            end
            default: begin
                if (r_stg_byte != w_addr8) begin
                    w_emit       = 1'b1;
                    n_out_status = afr_pkg::ST_BAD_ADDR;
                end else begin
                    n_pos = afr_pkg::POS_A;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_status <= n_out_status;
        end
    end

    // held duty values only change when a result is loaded, so they stay with it
    assign o_res.valid  = r_out_valid;
    assign o_res.status = r_out_status;
    assign o_res.duty_a = r_duty_a;
    assign o_res.duty_b = r_duty_b;

    a_sum_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_pos == afr_pkg::POS_SUM) |=> (r_pos == afr_pkg::POS_IDLE && r_out_valid))
        else $error("frame end did not return to idle with a result");

    a_fail_keeps_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit && n_out_status != afr_pkg::ST_OK) |=>
            ($stable(r_duty_a) && $stable(r_duty_b)))
        else $error("duty values changed on a failed result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> ($stable(r_out_status) && $stable(r_duty_a)))
        else $error("pending result overwritten");

    a_bad_lead_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_pos == afr_pkg::POS_IDLE && r_stg_byte != w_addr8) |=>
            (r_pos == afr_pkg::POS_IDLE && r_out_status == afr_pkg::ST_BAD_ADDR))
        else $error("mismatching lead byte started a frame");

endmodule

`default_nettype wire

// ===== bench/afr_checker.sv =====
// frame result checker: predicts status and held duty values from the accepted byte items
// depends on afr_pkg and the channel interfaces in afr_if.sv
`timescale 1ns / 1ps

module afr_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [afr_pkg::ADDR_W-1:0] i_cfg_wdata,
    afr_byte_if                        rx_ch,
    afr_result_if                      res_ch,
    output int                         o_fail_count,
    output int                         o_checked,
    output int                         o_pending,
    output logic                       o_frame_open
);

    typedef struct packed {
        afr_pkg::t_status           status;
        logic [afr_pkg::BYTE_W-1:0] duty_a;
        logic [afr_pkg::BYTE_W-1:0] duty_b;
    } t_frame_result;

    t_frame_result              due_q[$];
    t_frame_result              oldest;
    afr_pkg::t_pos              pos;
    logic [afr_pkg::BYTE_W-1:0] cand_a;
    logic [afr_pkg::BYTE_W-1:0] cand_b;
    logic [afr_pkg::BYTE_W-1:0] xor_seen;
    logic [afr_pkg::BYTE_W-1:0] held_a;
    logic [afr_pkg::BYTE_W-1:0] held_b;
    logic [afr_pkg::ADDR_W-1:0] node_addr;
    int                         mismatches = 0;
    int                         checked = 0;

    assign o_fail_count = mismatches;
    assign o_checked    = checked;

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // advance the frame state by one accepted byte item
    task automatic decode_byte(input logic [afr_pkg::BYTE_W-1:0] b);
        logic [afr_pkg::BYTE_W-1:0] addr8;
        logic [afr_pkg::BYTE_W-1:0] x;
        logic [afr_pkg::BYTE_W-1:0] s;
        logic                       emit;
        t_frame_result              r;
        addr8 = {{(afr_pkg::BYTE_W - afr_pkg::ADDR_W){1'b0}}, node_addr};
        emit = 1'b0;
        r.status = afr_pkg::ST_OK;
        case (pos)
            afr_pkg::POS_A: begin
                cand_a = b;
                pos = afr_pkg::POS_B;
            end
            afr_pkg::POS_B: begin
                cand_b = b;
                pos = afr_pkg::POS_XOR;
            end
            afr_pkg::POS_XOR: begin
                xor_seen = b;
                pos = afr_pkg::POS_SUM;
            end
            afr_pkg::POS_SUM: begin
                pos = afr_pkg::POS_IDLE;
                emit = 1'b1;
                x = addr8 ^ cand_a ^ cand_b;
                s = addr8 + cand_a + cand_b;
                // xor check wins when both are wrong
                if (x != xor_seen) begin
                    r.status = afr_pkg::ST_XOR_FAIL;
                end else if (s != b) begin
                    r.status = afr_pkg::ST_SUM_FAIL;
                end else begin
                    held_a = cand_a;
                    held_b = cand_b;
                end
            end
            default: begin
                if (b != addr8) begin
                    pos = afr_pkg::POS_IDLE;
                    emit = 1'b1;
                    r.status = afr_pkg::ST_BAD_ADDR;
                end else begin
                    pos = afr_pkg::POS_A;
                end
            end
        endcase
        if (emit) begin
            r.duty_a = held_a;
            r.duty_b = held_b;
            due_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pos = afr_pkg::POS_IDLE;
            cand_a = '0;
            cand_b = '0;
            xor_seen = '0;
            held_a = '0;
            held_b = '0;
            node_addr = '0;
            due_q.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (due_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result item, status %0d",
                                              res_ch.status));
                end else begin
                    oldest = due_q.pop_front();
                    checked++;
                    check_field("status", 8'(res_ch.status), 8'(oldest.status));
                    check_field("duty_a", res_ch.duty_a, oldest.duty_a);
                    check_field("duty_b", res_ch.duty_b, oldest.duty_b);
                end
            end
            if (rx_ch.valid && rx_ch.ready)
                decode_byte(rx_ch.rx_byte);
            if (i_cfg_we)
                node_addr = i_cfg_wdata;
        end
        o_pending    <= due_q.size();
        o_frame_open <= (pos != afr_pkg::POS_IDLE);
    end

endmodule

// ===== bench/addressed_frame_receiver_test.sv =====
// testbench top for the addressed frame receiver: clock, reset, byte stimulus, stalls, verdict
// depends on afr_pkg, afr_if.sv, the block itself and afr_checker.sv
`timescale 1ns / 1ps

module addressed_frame_receiver_test;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_BLOCKS
    } t_ready_mode;

    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 200;
    localparam int PIPE_SETTLE  = 4;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       cfg_we;
    logic [afr_pkg::ADDR_W-1:0] cfg_wdata;
    int                         fail_count;
    int                         checked;
    int                         pending;
    logic                       frame_open;

    int                         burst_left = 0;
    int                         bytes_sent = 0;
    int                         addr_writes = 0;
    logic [afr_pkg::ADDR_W-1:0] cur_addr = '0;
    t_ready_mode                ready_mode = RDY_ALWAYS;
    logic [7:0]                 stall_tick = '0;

    afr_byte_if   rx_ch ();
    afr_result_if res_ch ();

    addressed_frame_receiver uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_rx        (rx_ch),
        .o_res       (res_ch)
    );

    afr_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .rx_ch        (rx_ch),
        .res_ch       (res_ch),
        .o_fail_count (fail_count),
        .o_checked    (checked),
        .o_pending    (pending),
        .o_frame_open (frame_open)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result side stall pattern, mode picked at random whenever the low six tick bits are zero
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 8'd1;
        if (stall_tick[5:0] == 6'd0)
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
        case (ready_mode)
            RDY_ALWAYS: res_ch.ready <= 1'b1;
            RDY_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
            default:    res_ch.ready <= (stall_tick[3:0] >= 4'd12);
        endcase
    end

    function automatic logic [7:0] rand_duty();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    // offer one byte item, with bursts and random gaps between them
    task automatic send_byte(input logic [afr_pkg::BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 48 : $urandom_range(1, 12);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    // masks flip bits of the check bytes to force a failing frame
    task automatic send_frame(input logic [7:0] lead, input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] xor_mask, input logic [7:0] sum_mask);
        send_byte(lead);
        send_byte(a);
        send_byte(b);
        send_byte((lead ^ a ^ b) ^ xor_mask);
        send_byte(8'(lead + a + b) ^ sum_mask);
    endtask

    // finish any open frame, drain, then write the node address
    task automatic set_address(input logic [afr_pkg::ADDR_W-1:0] addr);
        rx_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (frame_open) begin
            send_byte(8'($urandom));
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cur_addr = addr;
        addr_writes++;
    endtask

    initial begin
        #(4_000_000);
        $display("timeout with %0d results still due", pending);
        $display("addressed_frame_receiver verification failed");
        $finish;
    end

    initial begin
        int         sent_in_phase;
        int         pick;
        int         extra;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] lead;
        logic [7:0] xm;
        logic [7:0] sm;
        logic [3:0] hi;

        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset address of zero
        send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_byte(8'hFF);
        // upper nibble set must not match a zero-extended address
        send_byte(8'h10);
        // both checks wrong reports the xor failure
        send_frame(8'h00, 8'h12, 8'h34, 8'h80, 8'h01);
        send_frame(8'h00, 8'h01, 8'h01, 8'h00, 8'h02);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)
                set_address(4'hF);
            else if (p == 1)
                set_address(4'h0);
            else
                set_address(4'($urandom_range(0, 15)));
            sent_in_phase = bytes_sent;
            while (bytes_sent - sent_in_phase < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                lead = {4'h0, cur_addr};
                if (pick < 72) begin
                    a  = rand_duty();
                    b  = rand_duty();
                    xm = 8'h00;
                    sm = 8'h00;
                    case ($urandom_range(0, 9))
                        7, 8:    xm = 8'($urandom_range(1, 255));
                        9:       sm = 8'($urandom_range(1, 255));
                        default: ;
                    endcase
                    send_frame(lead, a, b, xm, sm);
                end else if (pick < 84) begin
                    send_byte(8'($urandom));
                end else if (pick < 92) begin
                    hi = 4'($urandom_range(1, 15));
                    send_byte({hi, cur_addr});
                end else begin
                    // frame cut short, following items complete it
                    send_byte(lead);
                    extra = $urandom_range(1, 3);
                    repeat (extra) send_byte(8'($urandom));
                end
            end
        end

        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d byte items under %0d address writes, %0d results compared",
                 bytes_sent, addr_writes, checked);
        if (fail_count == 0) begin
            $display("addressed_frame_receiver verification clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("addressed_frame_receiver verification failed");
        end
        $finish;
    end

endmodule
